FILE: design/ppi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ppi_pkg;
  localparam int CordicStepsDefault = 24;
  localparam logic [23:0] TickPeriodReset = 24'd559241;
  localparam logic [31:0] TimeoutReset = 32'd200000;
  localparam logic [31:0] CordicGain = 32'd652032874;

  localparam logic [2:0] RegTickPeriod = 3'd0;
  localparam logic [2:0] RegTimeout = 3'd1;
  localparam logic [2:0] RegInitX = 3'd2;
  localparam logic [2:0] RegInitY = 3'd3;
  localparam logic [2:0] RegInitHeading = 3'd4;

  localparam logic KindCmd = 1'b0;
  localparam logic KindTick = 1'b1;

  // accepted tick handed to the back end
  typedef struct packed {
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] turn;
  } tick_job_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
        5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
        5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
        5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
        5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
        5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
        5'd30: r = 32'h00000001;
        default: r = 32'h00000000;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

FILE: design/ppi_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Takes words, keeps command state, filters ticks into a two-entry queue.
module ppi_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [103:0]        s_axis_tdata,
  input  wire logic                s_axis_tuser,
  input  wire logic [31:0]         timeout_us,
  output logic                     job_valid,
  input  wire logic                job_ready,
  output ppi_pkg::tick_job_t       job
);
  logic signed [23:0] cmd_vx, cmd_vy, cmd_turn;
  logic [31:0] last_cmd_time;
  logic cmd_seen;
  ppi_pkg::tick_job_t q [2];
  logic [1:0] count;
  logic rd_ptr, wr_ptr;
  logic acc, push, pop;
  logic [31:0] now, age;

  assign now = s_axis_tdata[31:0];
  assign age = now - last_cmd_time;
  assign s_axis_tready = (count != 2'd2);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign push = acc && (s_axis_tuser == ppi_pkg::KindTick) && cmd_seen
                && !(age > timeout_us);
  assign job_valid = (count != 2'd0);
  assign job = q[rd_ptr];
  assign pop = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vx <= '0; cmd_vy <= '0; cmd_turn <= '0;
      last_cmd_time <= '0; cmd_seen <= 1'b0;
      count <= '0; rd_ptr <= 1'b0; wr_ptr <= 1'b0;
    end else begin
      if (acc && s_axis_tuser == ppi_pkg::KindCmd) begin
        cmd_vx <= s_axis_tdata[55:32];
        cmd_vy <= s_axis_tdata[79:56];
        cmd_turn <= s_axis_tdata[103:80];
        last_cmd_time <= now;
        cmd_seen <= 1'b1;
      end
      if (push) begin
        q[wr_ptr] <= '{vx: cmd_vx, vy: cmd_vy, turn: cmd_turn};
        wr_ptr <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: design/ppi_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Scales, runs CORDIC iteratively, rotates, accumulates pose.
module ppi_back #(
  parameter int CORDIC_STEPS = ppi_pkg::CordicStepsDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  output logic                job_ready,
  input  wire ppi_pkg::tick_job_t job,
  input  wire logic [23:0]    tick_period,
  input  wire logic           ld_x,
  input  wire logic           ld_y,
  input  wire logic           ld_h,
  input  wire logic [31:0]    cfg_data,
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [95:0]         m_axis_tdata
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_SCALE = 8'b00000010, S_ROUND = 8'b00000100,
    S_CORD = 8'b00001000, S_MUL = 8'b00010000, S_SUM = 8'b00100000,
    S_ACC = 8'b01000000, S_OUT = 8'b10000000
  } state_t;
  state_t state;
  logic signed [31:0] pos_x, pos_y;
  logic [31:0] heading;
  ppi_pkg::tick_job_t jb;
  logic signed [48:0] px, py, pw;
  logic signed [33:0] dx, dy;
  logic [31:0] dw;
  logic signed [33:0] cx, cy, cz;
  logic flip;
  logic [4:0] it;
  logic signed [67:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [69:0] sum_x, sum_y;
  logic signed [33:0] xs, ys;
  logic signed [31:0] at;
  logic signed [69:0] rx, ry;
  logic signed [33:0] nx, ny;

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign job_ready = (state == S_IDLE);
  assign xs = cx >>> it;
  assign ys = cy >>> it;
  assign at = $signed(ppi_pkg::atan_lut(it));
  assign rx = (sum_x + (70'sd1 <<< 37)) >>> 38;
  assign ry = (sum_y + (70'sd1 <<< 37)) >>> 38;
  assign nx = 34'(pos_x) + rx[33:0];
  assign ny = 34'(pos_y) + ry[33:0];
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {heading, pos_y, pos_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos_x <= '0; pos_y <= '0; heading <= '0;
    end else begin
      if (ld_x) pos_x <= cfg_data;
      if (ld_y) pos_y <= cfg_data;
      if (ld_h) heading <= cfg_data;
      unique case (state)
        S_IDLE: if (job_valid) begin
          jb <= job;
          state <= S_SCALE;
        end
        S_SCALE: begin
          px <= jb.vx * $signed({1'b0, tick_period});
          py <= jb.vy * $signed({1'b0, tick_period});
          pw <= jb.turn * $signed({1'b0, tick_period});
          flip <= heading[31] ^ heading[30];
          cz <= 34'($signed(heading + ((heading[31] ^ heading[30]) ? 32'h80000000 : 32'h0)));
          cx <= 34'(ppi_pkg::CordicGain);
          cy <= '0;
          it <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          dx <= 34'((px + 49'sd32768) >>> 16);
          dy <= 34'((py + 49'sd32768) >>> 16);
          dw <= 32'((pw + 49'sd128) >>> 8);
          state <= S_CORD;
        end
        S_CORD: begin
          if (!cz[33]) begin
            cx <= cx - ys; cy <= cy + xs; cz <= cz - 34'(at);
          end else begin
            cx <= cx + ys; cy <= cy - xs; cz <= cz + 34'(at);
          end
          it <= it + 5'd1;
          if (32'(it) == CORDIC_STEPS - 1) state <= S_MUL;
        end
        S_MUL: begin
          p_xc <= dx * (flip ? -cx : cx);
          p_ys <= dy * (flip ? -cy : cy);
          p_xs <= dx * (flip ? -cy : cy);
          p_yc <= dy * (flip ? -cx : cx);
          state <= S_SUM;
        end
        S_SUM: begin
          sum_x <= 70'(p_xc) - 70'(p_ys);
          sum_y <= 70'(p_xs) + 70'(p_yc);
          state <= S_ACC;
        end
        S_ACC: begin
          pos_x <= sat(nx);
          pos_y <= sat(ny);
          heading <= heading + dw;
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/planar_pose_integrator.sv
`timescale 1ns / 1ps
`default_nettype none
// Planar pose integrator: command words (tuser 0) store body velocities and time;
// tick words (tuser 1) with a fresh command emit one pose word. Each tick passes
// through the back end states scale, round, the iterative CORDIC, multiply, sum,
// accumulate and output; the back end takes a new tick only once the last pose word
// is taken, and a two-entry queue lets the front take words meanwhile. Commands and
// dropped ticks stay in the front and never reach the back end.
module planar_pose_integrator #(
  parameter int CORDIC_STEPS = ppi_pkg::CordicStepsDefault
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [103:0] s_axis_tdata,  // time_us, vel_x, vel_y, yaw_rate
  input  wire logic         s_axis_tuser,  // kind
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata,  // pos_x, pos_y, heading
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  logic [23:0] tick_period;
  logic [31:0] timeout_us;
  logic job_valid, job_ready;
  ppi_pkg::tick_job_t job;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= ppi_pkg::TickPeriodReset;
      timeout_us <= ppi_pkg::TimeoutReset;
    end else if (cfg_we) begin
      if (cfg_index == ppi_pkg::RegTickPeriod) tick_period <= cfg_data[23:0];
      if (cfg_index == ppi_pkg::RegTimeout) timeout_us <= cfg_data;
    end
  end

  ppi_front u_front (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .timeout_us, .job_valid, .job_ready, .job
  );

  ppi_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job, .tick_period,
    .ld_x(cfg_we && cfg_index == ppi_pkg::RegInitX),
    .ld_y(cfg_we && cfg_index == ppi_pkg::RegInitY),
    .ld_h(cfg_we && cfg_index == ppi_pkg::RegInitHeading),
    .cfg_data, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );
endmodule
`default_nettype wire

FILE: sim/planar_pose_integrator_test.sv
`timescale 1ns / 1ps
module planar_pose_integrator_test;

  typedef struct {
    logic        kind;
    logic [31:0] time_us;
    logic [23:0] vx;
    logic [23:0] vy;
    logic [23:0] yr;
  } odo_word_t;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] hd;
  } pose_t;

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  odo_word_t pending_words[$];
  pose_t expected_poses[$];
  int errors = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_cycles = 0;
  bit no_idle = 0;
  int idle_count = 0;

  // predictor state
  logic [23:0] p_period;
  logic [31:0] p_timeout;
  logic signed [31:0] p_x, p_y;
  logic [31:0] p_head;
  logic signed [23:0] p_vx, p_vy, p_turn;
  logic [31:0] p_cmd_time;
  bit p_seen;

  localparam logic [31:0] AtanTab[24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

  planar_pose_integrator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint round_half_up(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [31:0] sat_q16(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  task automatic cordic_sincos(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] folded;
    logic [31:0] shifted;
    bit flip;
    longint x, y, z, xs, ys;
    shifted = ang + 32'h40000000;
    flip = shifted[31];
    folded = flip ? ang + 32'h80000000 : ang;
    z = longint'($signed(folded));
    x = 652032874;
    y = 0;
    for (int i = 0; i < ppi_pkg::CordicStepsDefault; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(AtanTab[i]);
      end else begin
        x += ys; y -= xs; z += longint'(AtanTab[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic advance_pose(input odo_word_t w);
    longint dx, dy, dw, c, s, tp;
    logic [31:0] age;
    pose_t p;
    if (w.kind == ppi_pkg::KindCmd) begin
      p_vx = w.vx; p_vy = w.vy; p_turn = w.yr;
      p_cmd_time = w.time_us;
      p_seen = 1;
      return;
    end
    age = w.time_us - p_cmd_time;
    if (!p_seen || age > p_timeout) return;
    tp = longint'(p_period);
    dx = round_half_up(longint'(p_vx) * tp, 16);
    dy = round_half_up(longint'(p_vy) * tp, 16);
    dw = round_half_up(longint'(p_turn) * tp, 8);
    cordic_sincos(p_head, c, s);
    p_x = sat_q16(longint'(p_x) + round_half_up(dx * c - dy * s, 38));
    p_y = sat_q16(longint'(p_y) + round_half_up(dx * s + dy * c, 38));
    p_head = p_head + dw[31:0];
    p.px = p_x; p.py = p_y; p.hd = p_head;
    expected_poses.push_back(p);
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    bit take;
    if (!rst) begin
      take = s_axis_tvalid && s_axis_tready;
      if (take) begin
        advance_pose(pending_words[0]);
        void'(pending_words.pop_front());
        in_gap = pick_gap();
      end
      if (!s_axis_tvalid || take) begin
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= pending_words[0].kind;
          s_axis_tdata <= {pending_words[0].yr, pending_words[0].vy,
                           pending_words[0].vx, pending_words[0].time_us};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pose_t e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_poses.size() == 0) begin
          errors++;
          $display("%0t: unexpected pose word %h", $realtime, m_axis_tdata);
        end else begin
          e = expected_poses.pop_front();
          if (m_axis_tdata[31:0] !== e.px) begin
            errors++;
            $display("%0t: pos_x expected %h actual %h", $realtime, e.px, m_axis_tdata[31:0]);
          end
          if (m_axis_tdata[63:32] !== e.py) begin
            errors++;
            $display("%0t: pos_y expected %h actual %h", $realtime, e.py, m_axis_tdata[63:32]);
          end
          if (m_axis_tdata[95:64] !== e.hd) begin
            errors++;
            $display("%0t: heading expected %h actual %h", $realtime, e.hd,
                     m_axis_tdata[95:64]);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        out_gap = (m_axis_tready && m_axis_tvalid) ? pick_gap() : 0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we ||
        (pending_words.size() == 0 && expected_poses.size() == 0))
      idle_count = 0;
    else
      idle_count++;
    if (idle_count >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      ppi_pkg::RegTickPeriod: p_period = val[23:0];
      ppi_pkg::RegTimeout: p_timeout = val;
      ppi_pkg::RegInitX: p_x = val;
      ppi_pkg::RegInitY: p_y = val;
      ppi_pkg::RegInitHeading: p_head = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || s_axis_tvalid || expected_poses.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic put_word(input logic kind, input logic [31:0] t,
                          input logic [23:0] vx, input logic [23:0] vy, input logic [23:0] yr);
    odo_word_t w;
    w.kind = kind; w.time_us = t; w.vx = vx; w.vy = vy; w.yr = yr;
    pending_words.push_back(w);
  endtask

  function automatic logic [23:0] rand_vel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'h7FFFFF;
    if (r == 1) return 24'h800000;
    if (r < 5) return 24'($urandom_range(0, 4095)) - 24'd2048;
    return 24'($urandom());
  endfunction

  task automatic random_words(input int count);
    int n;
    int nt;
    logic [31:0] t0;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        put_word(1'($urandom_range(0, 1)), $urandom(), 24'($urandom()), 24'($urandom()),
                 24'($urandom()));
        n++;
      end else begin
        t0 = $urandom();
        put_word(ppi_pkg::KindCmd, t0, rand_vel(), rand_vel(), rand_vel());
        nt = $urandom_range(1, 8);
        n += nt + 1;
        repeat (nt) begin
          if ($urandom_range(0, 9) == 0 && p_timeout != 32'hFFFFFFFF)
            put_word(ppi_pkg::KindTick, t0 + p_timeout + $urandom_range(1, 1000),
                     24'($urandom()), 24'($urandom()), 24'($urandom()));
          else
            put_word(ppi_pkg::KindTick, t0 + $urandom_range(0, p_timeout),
                     24'($urandom()), 24'($urandom()), 24'($urandom()));
        end
      end
    end
  endtask

  initial begin
    p_period = ppi_pkg::TickPeriodReset; p_timeout = ppi_pkg::TimeoutReset;
    p_x = 0; p_y = 0; p_head = 0;
    p_vx = 0; p_vy = 0; p_turn = 0; p_cmd_time = 0; p_seen = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed
    put_word(ppi_pkg::KindTick, 32'd100, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    put_word(ppi_pkg::KindCmd, 32'hFFFFFF00, 24'h7FFFFF, 24'h000000, 24'h7FFFFF);
    put_word(ppi_pkg::KindTick, 32'hFFFFFF00, '0, '0, '0);
    put_word(ppi_pkg::KindTick, 32'hFFFFFF00 + ppi_pkg::TimeoutReset, '0, '0, '0);
    put_word(ppi_pkg::KindTick, 32'hFFFFFF01 + ppi_pkg::TimeoutReset, '0, '0, '0);
    put_word(ppi_pkg::KindCmd, 32'd0, 24'h800000, 24'h800000, 24'h800000);
    put_word(ppi_pkg::KindTick, 32'd5, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    put_word(ppi_pkg::KindTick, 32'hFFFFFFFF, '0, '0, '0);
    put_word(ppi_pkg::KindCmd, 32'd50, 24'h000000, 24'h7FFFFF, 24'h400000);
    repeat (4) put_word(ppi_pkg::KindTick, 32'd60, '0, '0, '0);
    drain();
    write_reg(3'd5, 32'hFFFFFFFF);
    write_reg(3'd7, 32'h12345678);
    write_reg(ppi_pkg::RegTickPeriod, 32'h00FFFFFF);
    write_reg(ppi_pkg::RegTimeout, 32'hFFFFFFFF);
    write_reg(ppi_pkg::RegInitX, 32'h7FFF0000);
    write_reg(ppi_pkg::RegInitY, 32'h80000000);
    write_reg(ppi_pkg::RegInitHeading, 32'hC0000000);
    put_word(ppi_pkg::KindCmd, 32'd7, 24'h7FFFFF, 24'h7FFFFF, 24'h000001);
    repeat (4) put_word(ppi_pkg::KindTick, 32'd6, '0, '0, '0);
    drain();
    write_reg(ppi_pkg::RegTickPeriod, 32'd0);
    write_reg(ppi_pkg::RegTimeout, 32'd0);
    put_word(ppi_pkg::KindTick, 32'd7, '0, '0, '0);
    put_word(ppi_pkg::KindTick, 32'd8, '0, '0, '0);
    drain();

    // random phases across settings
    write_reg(ppi_pkg::RegTickPeriod, 32'd1);
    write_reg(ppi_pkg::RegInitHeading, 32'h3FFFFFFF);
    random_words(290);
    drain();
    write_reg(ppi_pkg::RegTickPeriod, 32'h00FFFFFF);
    write_reg(ppi_pkg::RegTimeout, 32'hFFFFFFFF);
    write_reg(ppi_pkg::RegInitX, 32'h80000000);
    write_reg(ppi_pkg::RegInitY, 32'h7FFFFFFF);
    hold_cycles = 400;
    no_idle = 1;
    random_words(290);
    drain();
    no_idle = 0;
    write_reg(ppi_pkg::RegTickPeriod, 32'(ppi_pkg::TickPeriodReset));
    write_reg(ppi_pkg::RegTimeout, ppi_pkg::TimeoutReset);
    write_reg(ppi_pkg::RegInitX, 32'd0);
    write_reg(ppi_pkg::RegInitY, 32'd0);
    write_reg(ppi_pkg::RegInitHeading, 32'h80000000);
    random_words(290);
    drain();
    write_reg(ppi_pkg::RegTickPeriod, $urandom_range(1, 24'hFFFFFF));
    write_reg(ppi_pkg::RegTimeout, $urandom_range(0, 5000));
    random_words(290);
    drain();
    write_reg(ppi_pkg::RegTickPeriod, 32'h00800000);
    write_reg(ppi_pkg::RegTimeout, 32'd1000000);
    write_reg(ppi_pkg::RegInitHeading, $urandom());
    random_words(290);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
design/ppi_pkg.sv
design/ppi_front.sv
design/ppi_back.sv
design/planar_pose_integrator.sv
sim/planar_pose_integrator_test.sv
